[src/lft_pkg.sv]
// Package for the label fixup table: sizes, item types, result codes,
// key normalization and field arithmetic. No dependencies.
package lft_pkg;

  localparam int LABEL_DEPTH   = 128;
  localparam int PENDING_DEPTH = 64;
  localparam int ADDR_BITS     = 13;
  localparam int KEY_CHARS     = 10;

  localparam int LAW = (LABEL_DEPTH > 1) ? $clog2(LABEL_DEPTH) : 1;
  localparam int LCW = $clog2(LABEL_DEPTH + 1);
  localparam int PAW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int PCW = $clog2(PENDING_DEPTH + 1);

  localparam logic [63:0] ADDR_MASK = (64'd1 << ADDR_BITS) - 64'd1;

  localparam logic [2:0] K_RESOLVED = 3'd0;
  localparam logic [2:0] K_DEFERRED = 3'd1;
  localparam logic [2:0] K_PATCH    = 3'd2;
  localparam logic [2:0] K_NONE     = 3'd3;
  localparam logic [2:0] K_DUP      = 3'd4;
  localparam logic [2:0] K_LFULL    = 3'd5;
  localparam logic [2:0] K_PFULL    = 3'd6;

  localparam logic FUNC_DEFINE = 1'b0;

  typedef struct packed {
    logic        func;
    logic [15:0] key_head;
    logic [63:0] key_tail;
    logic [63:0] def_value;
    logic [12:0] ref_address;
    logic        relative;
    logic [5:0]  field_width;
    logic [5:0]  field_shift;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] out_value;
    logic [12:0] patch_address;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] head;
    logic [63:0] tail;
  } key_t;

  typedef struct packed {
    key_t        key;
    logic [63:0] value;
  } lab_ent_t;

  typedef struct packed {
    key_t        key;
    logic [12:0] address;
    logic        relative;
    logic [5:0]  width;
    logic [5:0]  shift;
  } pend_ent_t;

  function automatic key_t norm_key(logic [15:0] h, logic [63:0] t);
    logic [79:0] w;
    logic [7:0]  c;
    logic        ended;
    key_t        k;
    w = {h, t};
    ended = 1'b0;
    for (int i = 0; i < 10; i++) begin
      c = w[79-8*i -: 8];
      if (i >= KEY_CHARS || ended) c = 8'd0;
      if (c == 8'd0) ended = 1'b1;
      w[79-8*i -: 8] = c;
    end
    k.head = w[79:64];
    k.tail = w[63:0];
    return k;
  endfunction

  function automatic logic [63:0] field_value(logic [63:0] val, logic [12:0] addr,
                                              logic rel, logic [5:0] width,
                                              logic [5:0] shift);
    logic [63:0] v;
    v = rel ? (val - {51'd0, addr}) : val;
    v = v & ((64'd1 << width) - 64'd1);
    return v << shift;
  endfunction

endpackage

[src/lft_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module lft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[src/label_fixup_table_core.sv]
// Label fixup table top level: control sequencer, label and pending RAMs,
// output register. Depends on lft_pkg and lft_ram.
//
// Usage: items arrive on req (req_valid/req_stall) and results leave on rsp
// (rsp_valid/rsp_stall). An item is taken when valid is high and stall low.
// A reference gives one result (resolved, deferred or pending full). A
// define gives one result (duplicate, label full, defined with none pending)
// or one patch result per matching pending entry, the final one with last.
// Only one item is in work at a time. The label table is scanned through
// its RAM read port at one entry per cycle; then a define walks the pending
// RAM entry by entry and moves the last entry into the hole of each match.
// req_stall is high whenever an item is in work. A stalled rsp holds its
// item; the sequencer waits while a new result has no room.
// Reset clears both entry counts; RAM contents need no clearing.
module label_fixup_table_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  lft_pkg::in_item_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output lft_pkg::out_item_t rsp
);
  import lft_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_LSCAN  = 8'b0000_0010,
    S_DECIDE = 8'b0000_0100,
    S_PRD    = 8'b0000_1000,
    S_PCMP   = 8'b0001_0000,
    S_PLAST  = 8'b0010_0000,
    S_PMOVE  = 8'b0100_0000,
    S_PEND   = 8'b1000_0000
  } state_t;

  state_t      state;
  in_item_t    item;
  key_t        key;
  logic [LCW-1:0] label_count;
  logic [PCW-1:0] pend_count;
  logic [LCW-1:0] ridx;
  logic        lcmp_v;
  logic        found;
  logic [63:0] lval;
  logic [PCW-1:0] pidx;
  logic        hold_v;
  logic [63:0] hold_val;
  logic [12:0] hold_addr;

  lab_ent_t    lab_wdata, lab_rdata;
  logic        lab_we;
  pend_ent_t   pend_wdata, pend_rdata;
  logic        pend_we;
  logic [PAW-1:0] pend_waddr, pend_raddr, pend_last_idx;

  logic        out_free, l_match, p_match, lfull, pfull, def_ins, ref_park;
  logic        p_take, emit_v;
  out_item_t   emit_item;
  logic [12:0] addr_m;

  lft_ram #(.WIDTH($bits(lab_ent_t)), .DEPTH(LABEL_DEPTH)) u_lab_ram (
    .clk(clk), .we(lab_we), .waddr(label_count[LAW-1:0]), .wdata(lab_wdata),
    .raddr(ridx[LAW-1:0]), .rdata(lab_rdata)
  );

  lft_ram #(.WIDTH($bits(pend_ent_t)), .DEPTH(PENDING_DEPTH)) u_pend_ram (
    .clk(clk), .we(pend_we), .waddr(pend_waddr), .wdata(pend_wdata),
    .raddr(pend_raddr), .rdata(pend_rdata)
  );

  assign req_stall     = (state != S_IDLE);
  assign out_free      = !rsp_valid || !rsp_stall;
  assign addr_m        = item.ref_address & ADDR_MASK[12:0];
  assign l_match       = lcmp_v && (lab_rdata.key == key);
  assign p_match       = (pend_rdata.key == key);
  assign lfull         = (label_count >= LCW'(LABEL_DEPTH));
  assign pfull         = (pend_count >= PCW'(PENDING_DEPTH));
  assign def_ins       = (item.func == FUNC_DEFINE) && !found && !lfull;
  assign ref_park      = (item.func != FUNC_DEFINE) && !found && !pfull;
  assign p_take        = p_match && (!hold_v || out_free);
  assign pend_last_idx = PAW'(pend_count - PCW'(1));

  always_comb begin
    lab_we = (state == S_DECIDE) && def_ins;
    lab_wdata.key = key;
    lab_wdata.value = item.def_value;

    pend_raddr = (state == S_PLAST || state == S_PMOVE) ? pend_last_idx
                                                        : pidx[PAW-1:0];
    pend_we = ((state == S_DECIDE) && ref_park && out_free) || (state == S_PMOVE);
    pend_waddr = (state == S_PMOVE) ? pidx[PAW-1:0] : pend_count[PAW-1:0];
    if (state == S_PMOVE) begin
      pend_wdata = pend_rdata;
    end else begin
      pend_wdata.key = key;
      pend_wdata.address = addr_m;
      pend_wdata.relative = item.relative;
      pend_wdata.width = item.field_width;
      pend_wdata.shift = item.field_shift;
    end

    emit_v = 1'b0;
    emit_item = '0;
    emit_item.last = 1'b1;
    case (state)
      S_DECIDE: begin
        if (!def_ins && out_free) begin
          emit_v = 1'b1;
          if (item.func == FUNC_DEFINE) begin
            emit_item.kind = found ? K_DUP : K_LFULL;
          end else if (found) begin
            emit_item.kind = K_RESOLVED;
            emit_item.out_value = field_value(lval, addr_m, item.relative,
                                              item.field_width, item.field_shift);
          end else begin
            emit_item.kind = pfull ? K_PFULL : K_DEFERRED;
          end
        end
      end
      S_PCMP: begin
        if (p_match && hold_v && out_free) begin
          emit_v = 1'b1;
          emit_item.kind = K_PATCH;
          emit_item.out_value = hold_val;
          emit_item.patch_address = hold_addr;
          emit_item.last = 1'b0;
        end
      end
      S_PEND: begin
        if (out_free) begin
          emit_v = 1'b1;
          if (hold_v) begin
            emit_item.kind = K_PATCH;
            emit_item.out_value = hold_val;
            emit_item.patch_address = hold_addr;
          end else begin
            emit_item.kind = K_NONE;
          end
        end
      end
      default: emit_v = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      label_count <= '0;
      pend_count <= '0;
      rsp_valid <= 1'b0;
      lcmp_v <= 1'b0;
      hold_v <= 1'b0;
    end else begin
      if (emit_v) begin
        rsp <= emit_item;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            item <= req;
            key <= norm_key(req.key_head, req.key_tail);
            ridx <= '0;
            lcmp_v <= 1'b0;
            found <= 1'b0;
            state <= S_LSCAN;
          end
        end
        S_LSCAN: begin
          if (l_match) begin
            found <= 1'b1;
            lval <= lab_rdata.value;
            lcmp_v <= 1'b0;
            state <= S_DECIDE;
          end else if (ridx < label_count) begin
            ridx <= ridx + LCW'(1);
            lcmp_v <= 1'b1;
          end else begin
            lcmp_v <= 1'b0;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (def_ins) begin
            label_count <= label_count + LCW'(1);
            pidx <= '0;
            hold_v <= 1'b0;
            state <= S_PRD;
          end else if (out_free) begin
            if (ref_park) pend_count <= pend_count + PCW'(1);
            state <= S_IDLE;
          end
        end
        S_PRD: begin
          state <= (pidx < pend_count) ? S_PCMP : S_PEND;
        end
        S_PCMP: begin
          if (p_take) begin
            hold_v <= 1'b1;
            hold_val <= field_value(item.def_value, pend_rdata.address,
                                    pend_rdata.relative, pend_rdata.width,
                                    pend_rdata.shift);
            hold_addr <= pend_rdata.address;
            state <= S_PLAST;
          end else if (!p_match) begin
            pidx <= pidx + PCW'(1);
            state <= S_PRD;
          end
        end
        S_PLAST: state <= S_PMOVE;
        S_PMOVE: begin
          pend_count <= pend_count - PCW'(1);
          state <= S_PRD;
        end
        S_PEND: begin
          if (out_free) begin
            hold_v <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend_count <= PCW'(PENDING_DEPTH)) else $error("pending count overflow");
  a_lab_bound: assert property (@(posedge clk) disable iff (rst)
    label_count <= LCW'(LABEL_DEPTH)) else $error("label count overflow");
  a_move_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_PMOVE |-> pend_count != '0) else $error("move from empty table");
  a_idle_no_hold: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !hold_v) else $error("patch left held at idle");
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    emit_v |-> out_free) else $error("result emitted without room");
endmodule

[tb/label_fixup_table_core_test.sv]
// Testbench for label_fixup_table_core: directed and random define/reference
// traffic checked against an in-bench symbol table model. Depends on lft_pkg.
module label_fixup_table_core_test;
  import lft_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  in_item_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  out_item_t rsp;

  label_fixup_table_core DUT (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  key_t        lab_key [LABEL_DEPTH];
  logic [63:0] lab_val [LABEL_DEPTH];
  int          lab_n;
  pend_ent_t   pend [PENDING_DEPTH];
  int          pend_n;
  out_item_t   results_due [$];
  int          errors;
  int          items_sent;
  int          results_seen;
  key_t        known [$];
  int          rsp_wait = -1;

  task automatic report(input string what, input out_item_t got, input out_item_t want);
    errors++;
    $display("mismatch %s: got k%0d v%h a%h l%b, want k%0d v%h a%h l%b", what,
             got.kind, got.out_value, got.patch_address, got.last,
             want.kind, want.out_value, want.patch_address, want.last);
  endtask

  function automatic key_t clean_key(logic [15:0] h, logic [63:0] t);
    logic [79:0] w;
    logic        ended;
    key_t        k;
    w = {h, t};
    ended = 1'b0;
    for (int i = 0; i < 10; i++) begin
      if (i >= KEY_CHARS || ended) w[79-8*i -: 8] = 8'd0;
      if (w[79-8*i -: 8] == 8'd0) ended = 1'b1;
    end
    k.head = w[79:64];
    k.tail = w[63:0];
    return k;
  endfunction

  function automatic logic [63:0] fixup_field(logic [63:0] v, logic [12:0] a, logic r,
                                              logic [5:0] w, logic [5:0] s);
    logic [63:0] x;
    x = r ? v - {51'd0, a} : v;
    x = x & ((64'd1 << w) - 64'd1);
    return x << s;
  endfunction

  function automatic out_item_t mk(logic [2:0] k, logic [63:0] v, logic [12:0] a, logic l);
    out_item_t o;
    o.kind = k;
    o.out_value = v;
    o.patch_address = a;
    o.last = l;
    return o;
  endfunction

  task automatic predict_symbols(input in_item_t it);
    key_t key;
    int   hit;
    int   i;
    int   n;
    key = clean_key(it.key_head, it.key_tail);
    hit = -1;
    for (i = 0; i < lab_n; i++)
      if (lab_key[i] == key) begin
        hit = i;
        break;
      end
    if (it.func != FUNC_DEFINE) begin
      if (hit >= 0)
        results_due.push_back(mk(K_RESOLVED, fixup_field(lab_val[hit], it.ref_address,
            it.relative, it.field_width, it.field_shift), '0, 1'b1));
      else if (pend_n >= PENDING_DEPTH)
        results_due.push_back(mk(K_PFULL, '0, '0, 1'b1));
      else begin
        pend[pend_n] = '{key, it.ref_address, it.relative, it.field_width, it.field_shift};
        pend_n++;
        results_due.push_back(mk(K_DEFERRED, '0, '0, 1'b1));
      end
      return;
    end
    if (hit >= 0) begin
      results_due.push_back(mk(K_DUP, '0, '0, 1'b1));
      return;
    end
    if (lab_n >= LABEL_DEPTH) begin
      results_due.push_back(mk(K_LFULL, '0, '0, 1'b1));
      return;
    end
    lab_key[lab_n] = key;
    lab_val[lab_n] = it.def_value;
    lab_n++;
    i = 0;
    n = 0;
    while (i < pend_n) begin
      if (pend[i].key != key) begin
        i++;
        continue;
      end
      results_due.push_back(mk(K_PATCH, fixup_field(it.def_value, pend[i].address,
          pend[i].relative, pend[i].width, pend[i].shift), pend[i].address, 1'b0));
      n++;
      pend_n--;
      pend[i] = pend[pend_n];
    end
    if (n == 0) results_due.push_back(mk(K_NONE, '0, '0, 1'b1));
    else results_due[$].last = 1'b1;
  endtask

  task automatic send_item(input in_item_t it);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    repeat (gap) @(negedge clk);
    req <= it;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predict_symbols(it);
    items_sent++;
    @(negedge clk);
    req_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      results_seen++;
      if (results_due.size() == 0) report("unexpected", rsp, rsp);
      else if (rsp !== results_due[0]) report("field", rsp, results_due.pop_front());
      else void'(results_due.pop_front());
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      rsp_wait = -1;
    end else if (rsp_valid) begin
      if (rsp_wait < 0) rsp_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
      if (rsp_wait > 0) begin
        rsp_stall <= 1'b1;
        rsp_wait--;
      end else begin
        rsp_stall <= 1'b0;
        rsp_wait = -1;
      end
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  function automatic in_item_t item_of(logic f, key_t k, logic [63:0] v);
    in_item_t it;
    it.func = f;
    it.key_head = k.head;
    it.key_tail = k.tail;
    it.def_value = v;
    it.ref_address = 13'($urandom_range(0, 8191));
    it.relative = 1'($urandom_range(0, 1));
    it.field_width = 6'($urandom_range(0, 63));
    it.field_shift = 6'($urandom_range(0, 63));
    return it;
  endfunction

  function automatic key_t random_key();
    key_t k;
    k.head = 16'($urandom);
    k.tail = {$urandom, $urandom};
    if ($urandom_range(0, 2) == 0) k.tail[8*$urandom_range(0, 7) +: 8] = 8'd0;
    return k;
  endfunction

  task automatic test_fields();
    in_item_t it;
    key_t     k;
    k = '{16'h4142, 64'h4344_4500_0000_0000};
    it = item_of(1'b1, k, '0);
    it.ref_address = 13'h1FFF; it.relative = 1'b1; it.field_width = 6'd63; it.field_shift = '0;
    send_item(it);
    it.ref_address = '0; it.relative = 1'b0; it.field_width = '0; it.field_shift = 6'd63;
    send_item(it);
    it.field_width = 6'd1; it.field_shift = 6'd63;
    send_item(it);
    it.key_tail = 64'h4344_4500_FFFF_FFFF; it.field_width = 6'd63; it.field_shift = 6'd5;
    send_item(it);
    send_item(item_of(1'b0, k, 64'hFFFF_FFFF_FFFF_FFFF));
    send_item(item_of(1'b0, k, 64'h0));
    it = item_of(1'b1, k, '0);
    it.relative = 1'b1; it.ref_address = 13'h1FFF; it.field_width = 6'd63;
    send_item(it);
    it.field_width = '0;
    send_item(it);
    k = '{16'h0041, 64'h0};
    send_item(item_of(1'b1, k, '0));
    send_item(item_of(1'b0, '{16'h00FF, 64'hFFFF_FFFF_FFFF_FFFF}, 64'h5));
    k = '{16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF};
    send_item(item_of(1'b1, k, '0));
    send_item(item_of(1'b0, k, 64'h0123_4567_89AB_CDEF));
    send_item(item_of(1'b0, '{16'hFF00, 64'h0}, 64'h1));
  endtask

  task automatic test_pending_full();
    key_t k;
    k = '{16'h5A5A, 64'h5A00_0000_0000_0000};
    while (pend_n < PENDING_DEPTH) send_item(item_of(1'b1, k, '0));
    send_item(item_of(1'b1, k, '0));
    send_item(item_of(1'b0, k, {$urandom, $urandom}));
  endtask

  task automatic test_random_traffic();
    key_t k;
    int   n;
    n = 0;
    while (n < 140) begin
      if (known.size() == 0 || $urandom_range(0, 3) == 0) begin
        k = random_key();
        known.push_back(k);
      end else k = known[$urandom_range(0, known.size() - 1)];
      if ($urandom_range(0, 2) != 0 && lab_n < LABEL_DEPTH - 8)
        send_item(item_of($urandom_range(0, 2) != 0, k, {$urandom, $urandom}));
      else
        send_item(item_of(1'($urandom_range(0, 1)), k, {$urandom, $urandom}));
      n++;
    end
  endtask

  task automatic test_label_full();
    key_t k;
    while (lab_n < LABEL_DEPTH) begin
      k = random_key();
      send_item(item_of(1'b0, k, {$urandom, $urandom}));
    end
    send_item(item_of(1'b0, random_key(), {$urandom, $urandom}));
    send_item(item_of(1'b1, lab_key[LABEL_DEPTH-1], '0));
    send_item(item_of(1'b1, random_key(), '0));
  endtask

  initial begin
    lab_n = 0;
    pend_n = 0;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_fields();
    test_pending_full();
    test_random_traffic();
    test_label_full();
    while (results_due.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("%0d items sent, %0d results checked: field extremes, both full tables,",
             items_sent, results_seen);
    $display("duplicates and multi-patch defines with random handshake gaps");
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end
endmodule

[sim.f]
src/lft_pkg.sv
src/lft_ram.sv
src/label_fixup_table_core.sv
tb/label_fixup_table_core_test.sv
